### rtl/core/nrpc_pkg.sv
// Package for the nearest palette color block.
// Holds field widths, codes, state encoding and the structs shared by the core modules.
package nrpc_pkg;

  localparam int DEF_ROWS = 8;
  localparam int DEF_COLS = 4;

  localparam int INDEX_W = 5;
  localparam int CHAN_W  = 8;
  localparam int COLOR_W = 3 * CHAN_W;
  localparam int ROW_W   = 3;
  localparam int COL_W   = 2;
  localparam int SQ_W    = 2 * CHAN_W;
  localparam int DIST_W  = 18;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } scan_tag_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [DIST_W-1:0] distance;
  } best_t;

endpackage

### rtl/core/nrpc_if.sv
// Valid/ready channel interfaces for the nearest palette color block.
// Depends on nrpc_pkg for field widths.
interface nrpc_req_if;
  import nrpc_pkg::*;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [INDEX_W-1:0] entry_index;
  logic [CHAN_W-1:0]  red;
  logic [CHAN_W-1:0]  green;
  logic [CHAN_W-1:0]  blue;
  modport source (output valid, kind, entry_index, red, green, blue, input ready);
  modport sink   (input valid, kind, entry_index, red, green, blue, output ready);
endinterface

interface nrpc_res_if;
  import nrpc_pkg::*;
  logic              valid;
  logic              ready;
  logic [ROW_W-1:0]  row_index;
  logic [COL_W-1:0]  column_index;
  logic [DIST_W-1:0] best_distance;
  modport source (output valid, row_index, column_index, best_distance, input ready);
  modport sink   (input valid, row_index, column_index, best_distance, output ready);
endinterface

### rtl/core/nrpc_mem.sv
// Single-port palette memory with a registered read.
// Depends on nrpc_pkg for the color width.
module nrpc_mem #(
  parameter int DEPTH = nrpc_pkg::DEF_ROWS * nrpc_pkg::DEF_COLS,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               addr,
  input  logic [nrpc_pkg::COLOR_W-1:0] wdata,
  output logic [nrpc_pkg::COLOR_W-1:0] rdata
);
  import nrpc_pkg::*;

  logic [COLOR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/core/nrpc_dist.sv
// Distance pipeline: squared channel differences, then sum and running minimum.
// Depends on nrpc_pkg for widths and the scan tag and best structs.
module nrpc_dist (
  input  logic                         clk,
  input  logic                         rst,
  input  nrpc_pkg::scan_tag_t          tag,
  input  logic [nrpc_pkg::COLOR_W-1:0] entry,
  input  logic [nrpc_pkg::COLOR_W-1:0] query,
  output logic                         done,
  output nrpc_pkg::best_t              best
);
  import nrpc_pkg::*;

  function automatic logic [SQ_W-1:0] chan_sq(input logic [CHAN_W-1:0] a,
                                               input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  scan_tag_t         tag_sq;
  logic [SQ_W-1:0]   sq_r;
  logic [SQ_W-1:0]   sq_g;
  logic [SQ_W-1:0]   sq_b;
  logic [DIST_W-1:0] sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_sq <= '0;
    end else begin
      tag_sq <= tag;
    end
    sq_r <= chan_sq(entry[3*CHAN_W-1:2*CHAN_W], query[3*CHAN_W-1:2*CHAN_W]);
    sq_g <= chan_sq(entry[2*CHAN_W-1:CHAN_W], query[2*CHAN_W-1:CHAN_W]);
    sq_b <= chan_sq(entry[CHAN_W-1:0], query[CHAN_W-1:0]);
  end

  assign sum = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tag_sq.valid && tag_sq.last;
    end
    if (tag_sq.valid && (tag_sq.first || (sum < best.distance))) begin
      best.row      <= tag_sq.row;
      best.col      <= tag_sq.col;
      best.distance <= sum;
    end
  end

endmodule

### rtl/core/nearest_palette_color.sv
// Nearest palette color: palette of ROWS x COLS RGB entries, one entry read per cycle.
// A query scans all ROWS*COLS entries through the one memory port, and no new item
// is taken until its result has been registered for output.
// Reset runs a clearing pass that zeroes all ROWS*COLS palette entries; no item
// is taken until it ends. Depends on nrpc_pkg, nrpc_if, nrpc_mem and nrpc_dist.
module nearest_palette_color #(
  parameter int ROWS = nrpc_pkg::DEF_ROWS,
  parameter int COLS = nrpc_pkg::DEF_COLS
) (
  input logic        clk,
  input logic        rst,
  nrpc_req_if.sink   request,
  nrpc_res_if.source result
);
  import nrpc_pkg::*;

  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;

  state_t             state;
  state_t             state_next;
  logic [AW-1:0]      addr;
  logic [RW-1:0]      row;
  logic [CW-1:0]      col;
  logic               addr_last;
  logic               req_fire;
  logic               in_range;
  logic               out_free;
  logic               out_load;
  logic [COLOR_W-1:0] query;
  scan_tag_t          issue_tag;
  scan_tag_t          tag;
  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic [COLOR_W-1:0] mem_wdata;
  logic [COLOR_W-1:0] mem_rdata;
  logic               done;
  best_t              best;

  assign addr_last = (addr == AW'(DEPTH - 1));
  assign req_fire  = request.valid && request.ready;
  assign in_range  = (32'(request.entry_index) < 32'(DEPTH));
  assign out_free  = !result.valid || result.ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (addr_last) state_next = ST_IDLE;
      ST_IDLE:  if (req_fire && request.kind == KIND_QUERY) state_next = ST_SCAN;
      ST_SCAN:  if (addr_last) state_next = ST_FLUSH;
      ST_FLUSH: begin
        if (done) begin
          state_next = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    request.ready = (state == ST_IDLE);
    out_load      = ((state == ST_FLUSH && done) || state == ST_HOLD) && out_free;
    mem_we        = 1'b0;
    mem_addr      = addr;
    mem_wdata     = '0;
    case (state)
      ST_CLEAR: mem_we = 1'b1;
      ST_IDLE: begin
        mem_addr  = AW'(request.entry_index);
        mem_wdata = {request.red, request.green, request.blue};
        mem_we    = req_fire && request.kind == KIND_LOAD && in_range;
      end
      default: ;
    endcase
  end

  always_comb begin
    issue_tag.valid = (state == ST_SCAN);
    issue_tag.first = (addr == '0);
    issue_tag.last  = addr_last;
    issue_tag.row   = ROW_W'(row);
    issue_tag.col   = COL_W'(col);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      addr  <= '0;
      row   <= '0;
      col   <= '0;
      tag   <= '0;
    end else begin
      state <= state_next;
      tag   <= issue_tag;
      if (state == ST_CLEAR || state == ST_SCAN) begin
        addr <= addr_last ? '0 : addr + AW'(1);
      end
      if (state == ST_SCAN) begin
        if (col == CW'(COLS - 1)) begin
          col <= '0;
          row <= row + RW'(1);
        end else begin
          col <= col + CW'(1);
        end
      end else begin
        row <= '0;
        col <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire && request.kind == KIND_QUERY) begin
      query <= {request.red, request.green, request.blue};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
    if (out_load) begin
      result.row_index     <= best.row;
      result.column_index  <= best.col;
      result.best_distance <= best.distance;
    end
  end

  nrpc_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  nrpc_dist u_dist (
    .clk   (clk),
    .rst   (rst),
    .tag   (tag),
    .entry (mem_rdata),
    .query (query),
    .done  (done),
    .best  (best)
  );

endmodule

### rtl/core/nrpc_checker.sv
// Port-level checks for the nearest palette color block, bound to the top level.
// Depends on nrpc_pkg for widths and codes.
module nrpc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        req_kind,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic [nrpc_pkg::ROW_W-1:0]  row_index,
  input logic [nrpc_pkg::COL_W-1:0]  column_index,
  input logic [nrpc_pkg::DIST_W-1:0] best_distance
);
  import nrpc_pkg::*;

  localparam logic [DIST_W-1:0] MAX_DIST = DIST_W'(195075);

  assert property (@(posedge clk) rst |=> !req_ready && !res_valid)
    else $error("block not quiet after reset");

  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_kind == KIND_QUERY |=> !req_ready)
    else $error("new beat taken during a scan");

  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> best_distance <= MAX_DIST)
    else $error("distance beyond reachable range");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(row_index)
      && $stable(column_index) && $stable(best_distance))
    else $error("stalled result beat changed");

endmodule

bind nearest_palette_color nrpc_checker u_nrpc_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (request.valid),
  .req_ready     (request.ready),
  .req_kind      (request.kind),
  .res_valid     (result.valid),
  .res_ready     (result.ready),
  .row_index     (result.row_index),
  .column_index  (result.column_index),
  .best_distance (result.best_distance)
);

### sim/testbench.sv
// Self-checking bench for nearest_palette_color: loads palette entries, queries colors,
// and checks row, column and squared distance of each result against a local palette copy.
// Depends on nrpc_pkg, nrpc_if and the nearest_palette_color RTL.
module testbench;
  import nrpc_pkg::*;

  localparam int PAL_ROWS     = DEF_ROWS;
  localparam int PAL_COLS     = DEF_COLS;
  localparam int PAL_DEPTH    = PAL_ROWS * PAL_COLS;
  localparam int INIT_BEST    = 999 * 999;
  localparam int DRAIN_CYCLES = 48;
  localparam int LIMIT_CYCLES = 600000;

  logic clk;
  logic rst;

  nrpc_req_if req_ch ();
  nrpc_res_if res_ch ();

  nearest_palette_color #(
    .ROWS(PAL_ROWS),
    .COLS(PAL_COLS)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .request(req_ch),
    .result (res_ch)
  );

  logic [COLOR_W-1:0] shadow_palette [PAL_DEPTH];
  best_t              nearest_queue [$];
  int                 error_count;
  int                 send_calm;
  int                 sink_calm;
  int                 stall_left;

  initial clk = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic best_t find_nearest(input logic [CHAN_W-1:0] r, g, b);
    best_t              found;
    int unsigned        best_d;
    int unsigned        d;
    int                 dr;
    int                 dg;
    int                 db;
    logic [COLOR_W-1:0] e;
    found  = '0;
    best_d = INIT_BEST;
    for (int y = 0; y < PAL_ROWS; y++) begin
      for (int x = 0; x < PAL_COLS; x++) begin
        e  = shadow_palette[y * PAL_COLS + x];
        dr = int'(e[23:16]) - int'(r);
        dg = int'(e[15:8]) - int'(g);
        db = int'(e[7:0]) - int'(b);
        d  = dr * dr + dg * dg + db * db;
        if (d < best_d) begin
          best_d    = d;
          found.row = ROW_W'(y);
          found.col = COL_W'(x);
        end
      end
    end
    found.distance = best_d[DIST_W-1:0];
    return found;
  endfunction

  function int idle_length(inout int calm);
    int pick;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) calm = $urandom_range(20, 60);
    pick = $urandom_range(0, 99);
    if (pick < 70) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task send_item(input logic kind, input logic [INDEX_W-1:0] idx,
                 input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                 input logic [CHAN_W-1:0] b);
    int gap;
    gap = idle_length(send_calm);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.kind        <= kind;
    req_ch.entry_index <= idx;
    req_ch.red         <= r;
    req_ch.green       <= g;
    req_ch.blue        <= b;
    do @(posedge clk); while (!req_ch.ready);
    if (kind == KIND_LOAD) begin
      if (int'(idx) < PAL_DEPTH) shadow_palette[idx] = {r, g, b};
    end else begin
      nearest_queue = {nearest_queue, find_nearest(r, g, b)};
    end
  endtask

  always @(posedge clk) begin
    best_t want;
    if (res_ch.valid && res_ch.ready) begin
      if (nearest_queue.size() == 0) begin
        $error("result with nothing pending: row_index %0d column_index %0d best_distance %0d",
               res_ch.row_index, res_ch.column_index, res_ch.best_distance);
        error_count++;
      end else begin
        want = nearest_queue.pop_front();
        if (res_ch.row_index !== want.row) begin
          $error("row_index expected %0d actual %0d", want.row, res_ch.row_index);
          error_count++;
        end
        if (res_ch.column_index !== want.col) begin
          $error("column_index expected %0d actual %0d", want.col, res_ch.column_index);
          error_count++;
        end
        if (res_ch.best_distance !== want.distance) begin
          $error("best_distance expected %0d actual %0d", want.distance,
                 res_ch.best_distance);
          error_count++;
        end
      end
    end
    if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      res_ch.ready <= 1'b1;
      stall_left = idle_length(sink_calm);
    end
  end

  task test_cleared_palette;
    send_item(KIND_QUERY, INDEX_W'($urandom), 8'h00, 8'h00, 8'h00);
    send_item(KIND_QUERY, INDEX_W'($urandom), 8'hFF, 8'hFF, 8'hFF);
    send_item(KIND_QUERY, INDEX_W'($urandom), 8'h80, 8'h01, 8'hFE);
  endtask

  task test_extreme_colors;
    send_item(KIND_LOAD, 5'd31, 8'hFF, 8'hFF, 8'hFF);
    send_item(KIND_LOAD, 5'd16, 8'hFF, 8'h00, 8'h00);
    send_item(KIND_LOAD, 5'd17, 8'h00, 8'hFF, 8'h00);
    send_item(KIND_LOAD, 5'd18, 8'h00, 8'h00, 8'hFF);
    send_item(KIND_QUERY, 5'd31, 8'hFF, 8'hFF, 8'hFF);
    send_item(KIND_QUERY, 5'd0, 8'hFF, 8'h00, 8'h00);
    send_item(KIND_QUERY, 5'd16, 8'h00, 8'hFF, 8'h00);
    send_item(KIND_QUERY, 5'd7, 8'h00, 8'h00, 8'hFF);
    send_item(KIND_QUERY, INDEX_W'($urandom), 8'h7F, 8'h7F, 8'h7F);
  endtask

  task test_ties;
    send_item(KIND_LOAD, 5'd5, 8'd10, 8'd20, 8'd30);
    send_item(KIND_LOAD, 5'd9, 8'd10, 8'd20, 8'd30);
    send_item(KIND_QUERY, 5'd9, 8'd10, 8'd20, 8'd30);
    send_item(KIND_LOAD, 5'd2, 8'd12, 8'd20, 8'd30);
    send_item(KIND_LOAD, 5'd3, 8'd8, 8'd20, 8'd30);
    send_item(KIND_QUERY, 5'd3, 8'd11, 8'd20, 8'd30);
  endtask

  task test_random_traffic(input int count);
    logic kind;
    for (int i = 0; i < count; i++) begin
      kind = ($urandom_range(0, 99) < 55) ? KIND_LOAD : KIND_QUERY;
      send_item(kind, INDEX_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
                CHAN_W'($urandom));
    end
  endtask

  // Draw channels from a coarse grid so equal distances, and thus ties, are common.
  function logic [CHAN_W-1:0] grid_channel();
    return CHAN_W'($urandom_range(0, 4) * 63 + $urandom_range(0, 1));
  endfunction

  task test_crowded_palette(input int count);
    logic kind;
    for (int i = 0; i < count; i++) begin
      kind = ($urandom_range(0, 99) < 50) ? KIND_LOAD : KIND_QUERY;
      send_item(kind, INDEX_W'($urandom), grid_channel(), grid_channel(), grid_channel());
    end
  endtask

  initial begin
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.kind        = KIND_LOAD;
    req_ch.entry_index = '0;
    req_ch.red         = '0;
    req_ch.green       = '0;
    req_ch.blue        = '0;
    res_ch.ready       = 1'b0;
    error_count        = 0;
    send_calm          = 0;
    sink_calm          = 0;
    stall_left         = 0;
    for (int i = 0; i < PAL_DEPTH; i++) shadow_palette[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_cleared_palette();
    test_extreme_colors();
    test_ties();
    test_random_traffic(700);
    test_crowded_palette(550);
    req_ch.valid <= 1'b0;
    while (nearest_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("testbench NOT OK");
    $finish;
  end

endmodule

### nearest_palette_color.f
rtl/core/nrpc_pkg.sv
rtl/core/nrpc_if.sv
rtl/core/nrpc_mem.sv
rtl/core/nrpc_dist.sv
rtl/core/nearest_palette_color.sv
rtl/core/nrpc_checker.sv
sim/testbench.sv
